### hdl/tlge_pkg.sv
// Shared constants and types for the toroidal life grid engine.
// No dependencies; imported by tlge_row_calc and the top level.
package tlge_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 24;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 5;
    localparam int CELLS_W = 32;

    localparam int ROW_AW = $clog2(GRID_HEIGHT);

    // Sweep schedule: reads, window shifts and write-back overlap over these steps
    localparam int SWEEP_LAST = GRID_HEIGHT + 3;
    localparam int CNT_W      = $clog2(SWEEP_LAST + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    typedef logic [GRID_WIDTH-1:0] row_t;

    typedef struct packed {
        row_t up;
        row_t cur;
        row_t dn;
    } window_t;

endpackage

### hdl/tlge_row_calc.sv
// Next-generation evaluation of one grid row from a three-row window (B3/S23).
// Depends on tlge_pkg for the row width and window type.
module tlge_row_calc (
    input  tlge_pkg::window_t win,
    output tlge_pkg::row_t    next_row
);
    import tlge_pkg::*;

    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
        localparam int LF = (c + GRID_WIDTH - 1) % GRID_WIDTH;
        localparam int RT = (c + 1) % GRID_WIDTH;
        logic [3:0] nb;

        // count the eight neighbours, wrapping left and right
        assign nb = 4'(win.up[LF])  + 4'(win.up[c])  + 4'(win.up[RT])
                  + 4'(win.cur[LF])                  + 4'(win.cur[RT])
                  + 4'(win.dn[LF])  + 4'(win.dn[c])  + 4'(win.dn[RT]);

        assign next_row[c] = (nb == 4'd3) || (win.cur[c] && (nb == 4'd2));
    end

endmodule

### hdl/toroidal_life_grid_engine_core.sv
// Top level of the toroidal life grid engine: row memory, sweep control, result register.
// Depends on tlge_pkg and tlge_row_calc.

// The block keeps a GRID_HEIGHT x GRID_WIDTH life grid (24 x 32 as built), one row per
// word of a single-port-read, single-port-write synchronous memory, with both edges
// wrapping round. Each request on the s_ channel carries a command: write row, read row
// or advance one generation (B3/S23); every request returns exactly one result on the
// m_ channel, which holds the row read, or zero for all other commands, for rows out of
// range and for the unused command code. A read answers from the registered memory
// output, so it waits in ST_RDWAIT for the data. In an advance the memory's single read
// port streams the rows through a three-row window, one row per cycle, and each new
// row is written back in place one step behind the window, with the original row 0
// kept aside for the wrap at the bottom. The result register parts the two channels,
// so a new request is taken while no request is in progress and the previous result
// is either gone or leaving. Reset clears the grid at once through a valid bit per
// row; a row never written reads as all dead, so no clearing pass is needed.
module toroidal_life_grid_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tlge_pkg::CMD_W-1:0]      s_command,
    input  logic [tlge_pkg::IDX_W-1:0]      s_row_index,
    input  logic [tlge_pkg::CELLS_W-1:0]    s_row_cells,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tlge_pkg::CELLS_W-1:0]    m_row_cells_out
);
    import tlge_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RDWAIT = 3'b010,
        ST_SWEEP  = 3'b100
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [GRID_HEIGHT-1:0] row_valid_reg;

    // payload state
    window_t                win_reg, win_next;
    row_t                   row0_reg, row0_next;
    logic [CELLS_W-1:0]     m_row_reg, m_row_next;
    logic                   rd_hit_reg, rd_hit_next;

    // row memory
    row_t                   grid_mem [GRID_HEIGHT];
    row_t                   rd_data_reg;
    logic                   rd_ok_reg;

    logic                   mem_rd_en;
    logic [ROW_AW-1:0]      mem_rd_addr;
    logic                   mem_wr_en;
    logic [ROW_AW-1:0]      mem_wr_addr;
    row_t                   mem_wr_data;

    row_t                   rd_row;
    row_t                   calc_row;
    logic                   in_acc;
    logic                   idx_ok;

    // a row never written since reset reads as all dead
    assign rd_row = rd_ok_reg ? rd_data_reg : '0;

    assign s_ready         = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid         = m_valid_reg;
    assign m_row_cells_out = m_row_reg;

    assign in_acc = s_valid && s_ready;
    assign idx_ok = int'(s_row_index) < GRID_HEIGHT;

    tlge_row_calc u_row_calc (
        .win      (win_reg),
        .next_row (calc_row)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        win_next     = win_reg;
        row0_next    = row0_reg;
        rd_hit_next  = rd_hit_reg;
        m_row_next   = m_row_reg;
        // drop the held result once it is taken
        m_valid_next = m_valid_reg && !m_ready;

        mem_rd_en   = 1'b0;
        mem_rd_addr = ROW_AW'(s_row_index);
        mem_wr_en   = 1'b0;
        mem_wr_addr = ROW_AW'(s_row_index);
        mem_wr_data = GRID_WIDTH'(s_row_cells);

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_command)
                        CMD_WRITE: begin
                            // ignore rows out of range; answer zero either way
                            mem_wr_en    = idx_ok;
                            m_valid_next = 1'b1;
                            m_row_next   = '0;
                        end
                        CMD_ADVANCE: begin
                            state_next = ST_SWEEP;
                            cnt_next   = '0;
                        end
                        CMD_READ: begin
                            mem_rd_en   = idx_ok;
                            rd_hit_next = idx_ok;
                            state_next  = ST_RDWAIT;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_row_next   = '0;
                        end
                    endcase
                end
            end

            ST_RDWAIT: begin
                m_valid_next = 1'b1;
                m_row_next   = rd_hit_reg ? CELLS_W'(rd_row) : '0;
                state_next   = ST_IDLE;
            end

            ST_SWEEP: begin
                cnt_next = cnt_reg + CNT_W'(1);

                // issue reads: last row first (upper neighbour of row 0), then rows in order
                if (cnt_reg <= CNT_W'(GRID_HEIGHT)) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = (cnt_reg == '0) ? ROW_AW'(GRID_HEIGHT - 1)
                                                  : ROW_AW'(cnt_reg - CNT_W'(1));
                end

                // advance the window; the final step wraps to the saved original row 0
                if ((cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(GRID_HEIGHT + 2))) begin
                    win_next.up  = win_reg.cur;
                    win_next.cur = win_reg.dn;
                    win_next.dn  = (cnt_reg == CNT_W'(GRID_HEIGHT + 2)) ? row0_reg : rd_row;
                end

                // hold the old row 0 before it is overwritten
                if (cnt_reg == CNT_W'(2)) begin
                    row0_next = rd_row;
                end

                // write back the new row centred in the window
                if (cnt_reg >= CNT_W'(4)) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = ROW_AW'(cnt_reg - CNT_W'(4));
                    mem_wr_data = calc_row;
                end

                if (cnt_reg == CNT_W'(SWEEP_LAST)) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_row_next   = '0;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (mem_wr_en) begin
                row_valid_reg[mem_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        row0_reg   <= row0_next;
        rd_hit_reg <= rd_hit_next;
        m_row_reg  <= m_row_next;
    end

    // row memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            grid_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= grid_mem[mem_rd_addr];
            rd_ok_reg   <= row_valid_reg[mem_rd_addr];
        end
    end

`ifndef SYNTH
    // no result may be pending while the sweep owns the block
    a_sweep_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !m_valid_reg)
        else $error("result pending during generation sweep");

    // the last sweep step returns to idle with the result presented
    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SWEEP) && (cnt_reg == CNT_W'(SWEEP_LAST)))
        |=> ((state_reg == ST_IDLE) && m_valid_reg))
        else $error("generation sweep did not complete");

    // a read request presents its result on leaving ST_RDWAIT
    a_read_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDWAIT) |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("read request gave no result");

    // memory writes happen only for a write request or during the sweep
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> ((state_reg == ST_SWEEP) || (in_acc && (s_command == CMD_WRITE))))
        else $error("unexpected memory write");
`endif

endmodule
